// File: hdl/psq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional sequence store package
// Shared operation and status codes, sequencer states and the cell control
// group used across the cell row.
// ----------------------------------------------------------------------------
package psq_pkg;

  // Width of the value ports, fixed by the interface.
  localparam int DATA_W = 32;

  // Cells per registered gather group of the read tree.
  localparam int GROUP = 8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_GATHER = 1'b1
  } state_t;

  // Shift commands broadcast to every cell of the row.
  typedef struct packed {
    logic ins_en;
    logic rem_en;
  } cell_ctl_t;

endpackage

// File: hdl/psq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequence cell
// One storage slot of the cell row. On an insert it loads its lower neighbor
// (or the write value where the position names it), on a remove its upper
// neighbor, and offers its value to the read tree at the named position.
// ----------------------------------------------------------------------------
module psq_cell #(
  parameter int INDEX       = 0,
  parameter int VALUE_WIDTH = 32,
  parameter int CNT_W       = 7
) (
  input  logic                    clk,
  input  psq_pkg::cell_ctl_t      ctl,
  input  logic [CNT_W-1:0]        pos,
  input  logic [VALUE_WIDTH-1:0]  wdata,
  input  logic [VALUE_WIDTH-1:0]  prev_value,
  input  logic [VALUE_WIDTH-1:0]  next_value,
  output logic [VALUE_WIDTH-1:0]  value,
  output logic [VALUE_WIDTH-1:0]  tap
);
  import psq_pkg::*;

  localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

  logic above;
  logic here;

  assign above = (IDX > pos);
  assign here  = (IDX == pos);

  always_ff @(posedge clk) begin
    if (ctl.ins_en && above) begin
      value <= prev_value;
    end else if (ctl.ins_en && here) begin
      value <= wdata;
    end else if (ctl.rem_en && (above || here)) begin
      value <= next_value;
    end
  end

  assign tap = here ? value : '0;

endmodule

// File: hdl/psq_group.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gather group
// First level of the read tree: ORs the taps of a small group of cells and
// registers the result. At most one tap in the row is nonzero.
// ----------------------------------------------------------------------------
module psq_group #(
  parameter int VALUE_WIDTH = 32,
  parameter int SIZE        = 8
) (
  input  logic                             clk,
  input  logic [SIZE-1:0][VALUE_WIDTH-1:0] taps,
  output logic [VALUE_WIDTH-1:0]           merged
);
  import psq_pkg::*;

  logic [VALUE_WIDTH-1:0] merged_next;

  always_comb begin
    merged_next = '0;
    for (int k = 0; k < SIZE; k++) begin
      merged_next = merged_next | taps[k];
    end
  end

  always_ff @(posedge clk) begin
    merged <= merged_next;
  end

endmodule

// File: hdl/positional_sequence_store_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional sequence store unit
// Ordered store of signed values with insert, read, remove and clear by
// position, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// A command beat is taken on a rising edge where start is high and busy is
// low. Every command gives exactly one result beat. The beat is loaded at the
// edge after the command edge and shown for a single cycle with done high.
// The receiver cannot stall it, so it must take the beat in that cycle. The
// unit takes no new command while busy: busy is high from a command edge to
// the result load, while the registered read tree (one group stage plus the
// final merge into the output register) gathers the addressed cell. A new
// command may be issued in the same cycle that the previous result is shown.
// The cell row itself shifts on the command edge, so an insert or remove is
// complete by the time busy drops. Errors (bad position, insert into a full
// store) leave the contents and count unchanged; read_value is zero for
// everything but a successful read or remove, and dropped_count is nonzero
// only for clear. Cell contents are not reset; only the fill count, the
// sequencer state and done are.
// ----------------------------------------------------------------------------
module positional_sequence_store_unit #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32,
  parameter int CNT_W       = $clog2(CAPACITY + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  operation,
  input  logic [CNT_W-1:0]            position,
  input  logic [psq_pkg::DATA_W-1:0]  write_value,
  output logic                        done,
  output logic [psq_pkg::DATA_W-1:0]  read_value,
  output logic [1:0]                  status,
  output logic [CNT_W-1:0]            element_count,
  output logic [CNT_W-1:0]            dropped_count
);
  import psq_pkg::*;

  localparam int NGROUPS = (CAPACITY + GROUP - 1) / GROUP;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  // Sequencer.
  state_t state;
  state_t state_next;
  logic   accept;

  // Command bookkeeping captured on the command edge.
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] fill_count_next;
  status_t          status_q;
  status_t          status_next;
  logic [CNT_W-1:0] dropped_q;
  logic [CNT_W-1:0] dropped_next;
  logic             rd_ok;
  logic             rd_ok_next;

  // Cell row.
  cell_ctl_t              ctl;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
  logic [VALUE_WIDTH-1:0] cell_tap   [CAPACITY];

  // Read tree.
  logic [NGROUPS-1:0][GROUP-1:0][VALUE_WIDTH-1:0] tap_grid;
  logic [VALUE_WIDTH-1:0] grp_or [NGROUPS];
  logic [VALUE_WIDTH-1:0] gathered;
  logic [DATA_W-1:0]      gathered_ext;

  assign busy   = (state == S_GATHER);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_GATHER;
      S_GATHER: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Decode the command against the current fill count.
  always_comb begin
    fill_count_next = fill_count;
    status_next     = ST_OK;
    dropped_next    = '0;
    rd_ok_next      = 1'b0;
    ctl             = '0;
    case (op_t'(operation))
      OP_INSERT: begin
        if (position > fill_count) begin
          status_next = ST_RANGE;
        end else if (fill_count == CAP) begin
          status_next = ST_FULL;
        end else begin
          ctl.ins_en      = accept;
          fill_count_next = fill_count + 1'b1;
        end
      end
      OP_READ, OP_REMOVE: begin
        if (position >= fill_count) begin
          status_next = ST_RANGE;
        end else begin
          rd_ok_next = 1'b1;
          if (operation == OP_REMOVE) begin
            ctl.rem_en      = accept;
            fill_count_next = fill_count - 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        dropped_next    = fill_count;
        fill_count_next = '0;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept) begin
      fill_count <= fill_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_q  <= status_next;
      dropped_q <= dropped_next;
      rd_ok     <= rd_ok_next;
    end
  end

  // The written value keeps its low bits, or is sign-extended when the cells
  // are wider than the port.
  generate
    if (VALUE_WIDTH <= DATA_W) begin : g_wr_narrow
      assign wdata = write_value[VALUE_WIDTH-1:0];
    end else begin : g_wr_wide
      assign wdata = {{(VALUE_WIDTH - DATA_W){write_value[DATA_W-1]}}, write_value};
    end
  endgenerate

  // The row of cells. Each cell sees its two neighbors; the ends see themselves,
  // which is harmless: cell 0 never takes that path, the last only on a remove.
  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] prev_v;
      logic [VALUE_WIDTH-1:0] next_v;
      if (i == 0) begin : g_first
        assign prev_v = cell_value[i];
      end else begin : g_mid_lo
        assign prev_v = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign next_v = cell_value[i];
      end else begin : g_mid_hi
        assign next_v = cell_value[i+1];
      end
      psq_cell #(
        .INDEX       (i),
        .VALUE_WIDTH (VALUE_WIDTH),
        .CNT_W       (CNT_W)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .pos        (position),
        .wdata      (wdata),
        .prev_value (prev_v),
        .next_value (next_v),
        .value      (cell_value[i]),
        .tap        (cell_tap[i])
      );
    end
  endgenerate

  // Group the taps, padding the last group with zeros.
  generate
    for (genvar g = 0; g < NGROUPS; g++) begin : g_grp
      for (genvar k = 0; k < GROUP; k++) begin : g_slot
        if (g * GROUP + k < CAPACITY) begin : g_used
          assign tap_grid[g][k] = cell_tap[g*GROUP+k];
        end else begin : g_pad
          assign tap_grid[g][k] = '0;
        end
      end
      psq_group #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .SIZE        (GROUP)
      ) u_group (
        .clk    (clk),
        .taps   (tap_grid[g]),
        .merged (grp_or[g])
      );
    end
  endgenerate

  always_comb begin
    gathered = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      gathered = gathered | grp_or[g];
    end
  end

  // Sign-extend the stored value to the port, or keep its low bits.
  generate
    if (VALUE_WIDTH >= DATA_W) begin : g_rd_wide
      assign gathered_ext = gathered[DATA_W-1:0];
    end else begin : g_rd_narrow
      assign gathered_ext = {{(DATA_W - VALUE_WIDTH){gathered[VALUE_WIDTH-1]}}, gathered};
    end
  endgenerate

  // Result register: loaded in the gather cycle, shown for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      read_value    <= rd_ok ? gathered_ext : '0;
      status        <= status_q;
      element_count <= fill_count;
      dropped_count <= dropped_q;
    end
  end

endmodule
